/* rtl/core/frame_deframer_crc16_check_defines.svh */
// ----------------------------------------------------------------------------
// frame_deframer_crc16_check_defines
// assertion macros for the frame deframer, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef FRAME_DEFRAMER_CRC16_CHECK_DEFINES_SVH
`define FRAME_DEFRAMER_CRC16_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
`define FDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdc same-cycle check failed");
`define FDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdc next-cycle check failed");
`else
`define FDC_ASSERT_IMP(lbl, ante, cons)
`define FDC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/fdc_pkg.sv */
// ----------------------------------------------------------------------------
// fdc_pkg
// types, constants and crc helper for the frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package fdc_pkg;

  localparam int unsigned POS_W    = 17;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned FIFO_D   = 4;
  localparam int unsigned FIFO_AW  = 2;
  localparam int unsigned FIFO_CW  = 3;

  localparam logic [POS_W-1:0] POS_MAX  = 17'h1FFFF;
  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

  localparam logic [7:0] START_RST = 8'hA5;
  localparam logic [7:0] MASK_RST  = 8'h80;

  // register index codes
  localparam logic REG_START = 1'b0;
  localparam logic REG_MASK  = 1'b1;

  // result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic             item_kind;
    logic [7:0]       data_byte;
    logic             frame_ok;
    logic [7:0]       seq_number;
    logic [7:0]       command_code;
    logic [7:0]       status_value;
    logic [LEN_W-1:0] data_length;
    logic             end_of_run;
  } res_t;

  // msb-first crc-16 update over one byte, no final xor
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != '0) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/fdc_if.sv */
// ----------------------------------------------------------------------------
// fdc_if
// valid/ready channels for input bytes and for results
// ----------------------------------------------------------------------------
`default_nettype none

interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  data_byte;
  logic        frame_ok;
  logic [7:0]  seq_number;
  logic [7:0]  command_code;
  logic [7:0]  status_value;
  logic [15:0] data_length;
  logic        end_of_run;

  modport source (output valid, output item_kind, output data_byte, output frame_ok,
                  output seq_number, output command_code, output status_value,
                  output data_length, output end_of_run, input ready);
  modport sink   (input valid, input item_kind, input data_byte, input frame_ok,
                  input seq_number, input command_code, input status_value,
                  input data_length, input end_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/core/frame_deframer_crc16_check.sv */
// ----------------------------------------------------------------------------
// frame_deframer_crc16_check
// byte-wise frame parser with crc-16 check, data pass-through and verdict
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  rx       | in  | valid/ready   | in_byte, buffer_end
//  tx       | out | valid/ready   | item_kind .. end_of_run
//  apb      | in  | psel/penable  | paddr, pwdata, prdata
//
//  one byte per cycle while rx.ready is high; frame fields and crc update in the accepting cycle
//  each byte pushes up to two results into a four-entry result queue
//  rx.ready is high while the queue holds two or fewer results
//  tx stalls fill the queue and then drop rx.ready; rst clears frame state and queue
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_deframer_crc16_check_defines.svh"

module frame_deframer_crc16_check (
  input  wire logic                         clk,
  input  wire logic                         rst,
  fdc_in_if.sink                            rx,
  fdc_out_if.source                         tx,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [fdc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                  pwdata,
  output      logic [31:0]                  prdata,
  output      logic                         pready
);

  logic [7:0] start_byte;
  logic [7:0] response_flag_mask;

  logic [fdc_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [fdc_pkg::LEN_W-1:0] length_field, length_field_next;
  logic [fdc_pkg::CRC_W-1:0] running_crc, running_crc_next;
  logic [fdc_pkg::CRC_W-1:0] received_crc, received_crc_next;
  logic                      start_matched, start_matched_next;
  logic [7:0]                seq_hold, seq_hold_next;
  logic [7:0]                command_hold, command_hold_next;
  logic [7:0]                status_hold, status_hold_next;

  fdc_pkg::res_t             ent [fdc_pkg::FIFO_D];
  logic [fdc_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [fdc_pkg::FIFO_CW-1:0] count;

  logic                      accept, pop, last;
  logic [7:0]                b;
  logic [fdc_pkg::POS_W-1:0] crc_end, pos_inc;
  logic                      is_data, ok;
  fdc_pkg::res_t             data_res, verdict_res;
  logic [1:0]                push_n;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte         <= fdc_pkg::START_RST;
      response_flag_mask <= fdc_pkg::MASK_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        fdc_pkg::REG_START: start_byte         <= pwdata[7:0];
        fdc_pkg::REG_MASK:  response_flag_mask <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      fdc_pkg::REG_START: prdata = {24'h0, start_byte};
      fdc_pkg::REG_MASK:  prdata = {24'h0, response_flag_mask};
      default:            prdata = '0;
    endcase
  end

  // frame field decode
  assign b       = rx.in_byte;
  assign last    = rx.buffer_end;
  assign accept  = rx.valid && rx.ready;
  assign crc_end = {1'b0, length_field} + fdc_pkg::POS_W'(5);
  assign pos_inc = (byte_position == fdc_pkg::POS_MAX) ? byte_position
                                                       : byte_position + 1'b1;

  always_comb begin
    length_field_next  = length_field;
    running_crc_next   = running_crc;
    received_crc_next  = received_crc;
    start_matched_next = start_matched;
    seq_hold_next      = seq_hold;
    command_hold_next  = command_hold;
    status_hold_next   = status_hold;
    is_data            = 1'b0;
    if (byte_position == fdc_pkg::POS_W'(0)) begin
      start_matched_next = (b == start_byte);
    end else if (byte_position == fdc_pkg::POS_W'(1)) begin
      length_field_next = {length_field[15:8], b};
    end else if (byte_position == fdc_pkg::POS_W'(2)) begin
      length_field_next = {b, length_field[7:0]};
    end else if (byte_position == fdc_pkg::POS_W'(3)) begin
      seq_hold_next    = b;
      running_crc_next = fdc_pkg::crc16_byte(running_crc, b);
    end else if (byte_position == fdc_pkg::POS_W'(4)) begin
      command_hold_next = b;
      running_crc_next  = fdc_pkg::crc16_byte(running_crc, b);
    end else if (byte_position < crc_end) begin
      running_crc_next = fdc_pkg::crc16_byte(running_crc, b);
      if (byte_position == fdc_pkg::POS_W'(5)) begin
        status_hold_next = b;
      end else begin
        is_data = 1'b1;
      end
    end else if (byte_position == crc_end) begin
      received_crc_next = {received_crc[15:8], b};
    end else if (byte_position == crc_end + 1'b1) begin
      received_crc_next = {b, received_crc[7:0]};
    end
  end

  assign byte_position_next = pos_inc;

  assign ok = start_matched_next && (length_field_next != '0) &&
              (pos_inc == {1'b0, length_field_next} + fdc_pkg::POS_W'(7)) &&
              (running_crc_next == received_crc_next);

  always_comb begin
    data_res            = '0;
    data_res.item_kind  = fdc_pkg::KIND_DATA;
    data_res.data_byte  = b;
    data_res.end_of_run = !last;

    verdict_res            = '0;
    verdict_res.item_kind  = fdc_pkg::KIND_VERDICT;
    verdict_res.frame_ok   = ok;
    verdict_res.end_of_run = 1'b1;
    if (ok) begin
      verdict_res.seq_number   = seq_hold_next;
      verdict_res.command_code = command_hold_next & ~response_flag_mask;
      verdict_res.status_value = status_hold_next;
      verdict_res.data_length  = length_field_next - 1'b1;
    end
  end

  assign push_n = accept ? (2'(is_data) + 2'(last)) : 2'd0;

  // frame state
  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      byte_position <= '0;
      length_field  <= '0;
      running_crc   <= fdc_pkg::CRC_INIT;
      received_crc  <= '0;
      start_matched <= 1'b0;
      seq_hold      <= '0;
      command_hold  <= '0;
      status_hold   <= '0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      length_field  <= length_field_next;
      running_crc   <= running_crc_next;
      received_crc  <= received_crc_next;
      start_matched <= start_matched_next;
      seq_hold      <= seq_hold_next;
      command_hold  <= command_hold_next;
      status_hold   <= status_hold_next;
    end
  end

  // result queue
  assign rx.ready = (count <= fdc_pkg::FIFO_CW'(2));
  assign pop      = tx.valid && tx.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_data) begin
        ent[wr_ptr] <= data_res;
        if (last) begin
          ent[wr_ptr + 1'b1] <= verdict_res;
        end
      end else if (last) begin
        ent[wr_ptr] <= verdict_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + fdc_pkg::FIFO_AW'(push_n);
      rd_ptr <= rd_ptr + fdc_pkg::FIFO_AW'(pop);
      count  <= count + fdc_pkg::FIFO_CW'(push_n) - fdc_pkg::FIFO_CW'(pop);
    end
  end

  assign tx.valid        = (count != '0);
  assign tx.item_kind    = ent[rd_ptr].item_kind;
  assign tx.data_byte    = ent[rd_ptr].data_byte;
  assign tx.frame_ok     = ent[rd_ptr].frame_ok;
  assign tx.seq_number   = ent[rd_ptr].seq_number;
  assign tx.command_code = ent[rd_ptr].command_code;
  assign tx.status_value = ent[rd_ptr].status_value;
  assign tx.data_length  = ent[rd_ptr].data_length;
  assign tx.end_of_run   = ent[rd_ptr].end_of_run;

  // checks
  `FDC_ASSERT_IMP(a_count_bound, 1'b1, count <= fdc_pkg::FIFO_CW'(fdc_pkg::FIFO_D))
  `FDC_ASSERT_NXT(a_frame_clear, accept && last, byte_position == '0 && running_crc == fdc_pkg::CRC_INIT)
  `FDC_ASSERT_NXT(a_verdict_queued, accept && last, tx.valid)
  `FDC_ASSERT_NXT(a_stall_holds, tx.valid && !tx.ready, count >= $past(count))

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame deframer with CRC-16 check. Frames are
// built with their own CRC and sent byte by byte, some of them damaged on
// purpose. A byte-level model of the parser predicts the data transfers and
// the verdicts. Every result is checked field by field against that model.
// Both sides of the stream stall at random, and the result side also holds
// off for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  typedef enum int {
    FLAW_NONE, FLAW_CRC, FLAW_SHORT, FLAW_EXTRA, FLAW_LEN, FLAW_CUT_DATA
  } flaw_t;

  logic                       clk     = 1'b0;
  logic                       rst     = 1'b1;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [fdc_pkg::ADDR_W-1:0] paddr   = '0;
  logic [31:0]                pwdata  = '0;
  wire  [31:0]                prdata;
  wire                        pready;

  fdc_in_if  rx_if ();
  fdc_out_if tx_if ();

  frame_deframer_crc16_check u_top (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_if),
    .tx      (tx_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  // parser model state
  logic [7:0]  cfg_start;
  logic [7:0]  cfg_mask;
  logic [16:0] frm_pos;
  logic [15:0] frm_len;
  logic [15:0] crc_calc;
  logic [15:0] crc_recv;
  logic        frm_start_ok;
  logic [7:0]  frm_seq;
  logic [7:0]  frm_cmd;
  logic [7:0]  frm_status;

  fdc_pkg::res_t pending_results[$];
  int   errors     = 0;
  int   bytes_sent = 0;
  bit   idle_on    = 1'b1;
  bit   hold_req   = 1'b0;

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? fdc_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    frm_pos      = '0;
    frm_len      = '0;
    crc_calc     = fdc_pkg::CRC_INIT;
    crc_recv     = '0;
    frm_start_ok = 1'b0;
    frm_seq      = '0;
    frm_cmd      = '0;
    frm_status   = '0;
  endfunction

  function automatic void deframe_model(input logic [7:0] b, input logic last);
    logic [16:0]   crc_end;
    fdc_pkg::res_t r;
    logic          ok;
    crc_end = 17'd5 + {1'b0, frm_len};
    if (frm_pos == 17'd0) begin
      frm_start_ok = (b == cfg_start);
    end else if (frm_pos == 17'd1) begin
      frm_len[7:0] = b;
    end else if (frm_pos == 17'd2) begin
      frm_len[15:8] = b;
    end else if (frm_pos == 17'd3 || frm_pos == 17'd4) begin
      if (frm_pos == 17'd3) begin
        frm_seq = b;
      end else begin
        frm_cmd = b;
      end
      crc_calc = crc16_next(crc_calc, b);
    end else if (frm_pos < crc_end) begin
      crc_calc = crc16_next(crc_calc, b);
      if (frm_pos == 17'd5) begin
        frm_status = b;
      end else begin
        r            = '0;
        r.item_kind  = fdc_pkg::KIND_DATA;
        r.data_byte  = b;
        r.end_of_run = !last;
        pending_results.push_back(r);
      end
    end else if (frm_pos == crc_end) begin
      crc_recv[7:0] = b;
    end else if (frm_pos == crc_end + 17'd1) begin
      crc_recv[15:8] = b;
    end
    if (frm_pos != fdc_pkg::POS_MAX) frm_pos = frm_pos + 17'd1;
    if (last) begin
      ok = frm_start_ok && (frm_len != 16'd0) && (frm_pos == {1'b0, frm_len} + 17'd7) &&
           (crc_calc == crc_recv);
      r           = '0;
      r.item_kind = fdc_pkg::KIND_VERDICT;
      r.frame_ok  = ok;
      if (ok) begin
        r.seq_number   = frm_seq;
        r.command_code = frm_cmd & ~cfg_mask;
        r.status_value = frm_status;
        r.data_length  = frm_len - 16'd1;
      end
      r.end_of_run = 1'b1;
      pending_results.push_back(r);
      clear_frame();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    rx_if.valid      <= 1'b1;
    rx_if.in_byte    <= b;
    rx_if.buffer_end <= last;
    do @(posedge clk); while (!rx_if.ready);
    deframe_model(b, last);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    rx_if.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    logic [31:0] rnd;
    rnd = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {rnd[31:8], value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == fdc_pkg::REG_START) begin
      cfg_start = value;
    end else begin
      cfg_mask = value;
    end
  endtask

  // fill < 0 gives random payload, else alternating fill and its inverse
  task automatic send_frame(input logic [7:0] sb, input logic [7:0] seq, input logic [7:0] cmd,
                            input int pay_n, input flaw_t flaw, input int fill);
    logic [7:0]  frame_bytes[$];
    logic [7:0]  pb;
    logic [15:0] crc;
    logic [15:0] len_val;
    int          keep;
    crc     = fdc_pkg::CRC_INIT;
    len_val = pay_n[15:0];
    if (flaw == FLAW_LEN) begin
      if ($urandom_range(0, 1) == 1) begin
        len_val = len_val + 16'($urandom_range(1, 3));
      end else begin
        len_val = len_val - 16'($urandom_range(1, 3));
      end
    end
    frame_bytes.push_back(sb);
    frame_bytes.push_back(len_val[7:0]);
    frame_bytes.push_back(len_val[15:8]);
    frame_bytes.push_back(seq);
    frame_bytes.push_back(cmd);
    crc = crc16_next(crc16_next(crc, seq), cmd);
    for (int i = 0; i < pay_n; i++) begin
      if (fill < 0) begin
        pb = 8'($urandom);
      end else begin
        pb = (i % 2 == 1) ? ~fill[7:0] : fill[7:0];
      end
      frame_bytes.push_back(pb);
      crc = crc16_next(crc, pb);
    end
    if (flaw == FLAW_CRC) begin
      if ($urandom_range(0, 1) == 1) begin
        crc[7:0] = crc[7:0] ^ 8'($urandom_range(1, 255));
      end else begin
        crc[15:8] = crc[15:8] ^ 8'($urandom_range(1, 255));
      end
    end
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    if (flaw == FLAW_EXTRA) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
    end
    if (flaw == FLAW_SHORT) begin
      keep = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
    if (flaw == FLAW_CUT_DATA && pay_n >= 2) begin
      keep = $urandom_range(7, 5 + pay_n);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic test_defaults();
    send_frame(fdc_pkg::START_RST, 8'h00, 8'hFF, 2, FLAW_NONE, 8'hFF);
    send_frame(fdc_pkg::START_RST, 8'hFF, 8'h80, 1, FLAW_NONE, 8'h00);
    wait_idle();
  endtask

  task automatic test_special_cases();
    // short buffer of one byte
    send_byte(fdc_pkg::START_RST, 1'b1);
    // zero length
    send_frame(fdc_pkg::START_RST, 8'h5A, 8'hA5, 0, FLAW_NONE, -1);
    // bytes past the crc
    send_frame(fdc_pkg::START_RST, 8'h11, 8'h22, 1, FLAW_EXTRA, -1);
    // buffer ends on a data byte
    send_frame(fdc_pkg::START_RST, 8'h33, 8'h44, 2, FLAW_CUT_DATA, -1);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(fdc_pkg::REG_START, 8'h00);
    write_reg(fdc_pkg::REG_MASK, 8'hFF);
    send_frame(8'h00, 8'h01, 8'hFF, 3, FLAW_NONE, -1);
    send_frame(fdc_pkg::START_RST, 8'h02, 8'hFF, 1, FLAW_NONE, -1);
    wait_idle();
    write_reg(fdc_pkg::REG_START, 8'hFF);
    write_reg(fdc_pkg::REG_MASK, 8'h00);
    send_frame(8'hFF, 8'h03, 8'hFF, 3, FLAW_NONE, -1);
    send_frame(8'hFF, 8'h04, 8'h81, 2, FLAW_CRC, -1);
    wait_idle();
    write_reg(fdc_pkg::REG_START, fdc_pkg::START_RST);
    write_reg(fdc_pkg::REG_MASK, fdc_pkg::MASK_RST);
    wait_idle();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (8) send_frame(cfg_start, 8'($urandom), 8'($urandom), $urandom_range(2, 8),
                          FLAW_NONE, -1);
    wait_idle();
  endtask

  task automatic test_random();
    int    first;
    int    k;
    int    pay_n;
    flaw_t flaw;
    logic [7:0] sb;
    first = bytes_sent;
    while (bytes_sent < first + 250) begin
      if (bytes_sent > first + 190) idle_on = 1'b0;
      if ($urandom_range(0, 11) == 0) begin
        wait_idle();
        if ($urandom_range(0, 1) == 1) write_reg(fdc_pkg::REG_START, 8'($urandom));
        if ($urandom_range(0, 1) == 1) write_reg(fdc_pkg::REG_MASK, 8'($urandom));
      end
      sb    = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_start;
      pay_n = $urandom_range(0, 12);
      k     = $urandom_range(0, 19);
      if (k >= 18) begin
        k = $urandom_range(1, 12);
        for (int i = 0; i < k; i++) send_byte(8'($urandom), i == k - 1);
      end else begin
        case (k)
          12:      flaw = FLAW_CRC;
          13:      flaw = FLAW_SHORT;
          14:      flaw = FLAW_EXTRA;
          15:      flaw = FLAW_LEN;
          16, 17:  flaw = FLAW_CUT_DATA;
          default: flaw = FLAW_NONE;
        endcase
        if (flaw == FLAW_CUT_DATA && pay_n < 2) pay_n = 2;
        send_frame(sb, 8'($urandom), 8'($urandom), pay_n, flaw, -1);
      end
    end
    wait_idle();
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    fdc_pkg::res_t got;
    fdc_pkg::res_t want;
    if (!rst && tx_if.valid && tx_if.ready) begin
      got.item_kind    = tx_if.item_kind;
      got.data_byte    = tx_if.data_byte;
      got.frame_ok     = tx_if.frame_ok;
      got.seq_number   = tx_if.seq_number;
      got.command_code = tx_if.command_code;
      got.status_value = tx_if.status_value;
      got.data_length  = tx_if.data_length;
      got.end_of_run   = tx_if.end_of_run;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result transfer with none expected, actual %0h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("item_kind", want.item_kind, got.item_kind);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("frame_ok", want.frame_ok, got.frame_ok);
        check_field("seq_number", want.seq_number, got.seq_number);
        check_field("command_code", want.command_code, got.command_code);
        check_field("status_value", want.status_value, got.status_value);
        check_field("data_length", want.data_length, got.data_length);
        check_field("end_of_run", want.end_of_run, got.end_of_run);
      end
    end
  end

  initial begin : result_ready
    int hold_left;
    int stall_left;
    hold_left    = 0;
    stall_left   = 0;
    tx_if.ready  = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        tx_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        tx_if.ready <= 1'b0;
      end else begin
        tx_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    rx_if.valid      = 1'b0;
    rx_if.in_byte    = 8'h00;
    rx_if.buffer_end = 1'b0;
    cfg_start        = fdc_pkg::START_RST;
    cfg_mask         = fdc_pkg::MASK_RST;
    clear_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_special_cases();
    test_config_extremes();
    test_backpressure();
    test_random();
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results expected but never seen", $time, pending_results.size());
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(64'd12 * 64'd200_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

/* frame_deframer_crc16_check.f */
+incdir+rtl/core
rtl/core/fdc_pkg.sv
rtl/core/fdc_if.sv
rtl/core/frame_deframer_crc16_check.sv
verif/tb_top.sv
